[rtl/ydrd_pkg.sv]
// ydrd_pkg: widths, types, register codes and fixed-point scaling constants
// for the detection row decoder; used by every other file in rtl
package ydrd_pkg;

  localparam int unsigned NET_WIDTH   = 640;
  localparam int unsigned NET_HEIGHT  = 640;
  localparam int unsigned MAX_CLASSES = 128;
  localparam int unsigned NET_DIM_MIN = 32;

  localparam int unsigned VAL_W     = 24;
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned DIM_W     = 15;
  localparam int unsigned CLS_W     = 8;
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned THR_W     = 13;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned PIX_W     = 15;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = DIM_W'(640);
  localparam logic [CLS_W-1:0] CLASS_COUNT_RST  = CLS_W'(1);
  localparam logic [THR_W-1:0] CONF_THR_RST     = THR_W'(2048);
  localparam logic [THR_W-1:0] SCORE_THR_RST    = THR_W'(2048);

  // row layout
  localparam logic [POS_W-1:0] POS_CX    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_CY    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_W_RAW = POS_W'(2);
  localparam logic [POS_W-1:0] POS_H_RAW = POS_W'(3);
  localparam logic [POS_W-1:0] POS_OBJ   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_CLS0  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(4 + MAX_CLASSES);

  // scaling datapath widths
  localparam int unsigned DIFF_W = VAL_W + 2;
  localparam int unsigned PROD_W = DIFF_W + DIM_W + 1;
  localparam int unsigned MAG_W  = PROD_W - 1;
  localparam int unsigned X_W    = MAG_W - FRAC_BITS;
  localparam int unsigned M_W    = X_W + 1;
  localparam int unsigned RP_W   = X_W + M_W;
  localparam int unsigned Q_W    = X_W - $clog2(NET_DIM_MIN);
  localparam int unsigned SUM_W  = Q_W + 2;

  // divide by a constant as multiply by a rounded-up reciprocal, exact for x below 2^X_W
  localparam int unsigned DIV_L = 2 * NET_WIDTH;
  localparam int unsigned DIV_T = 2 * NET_HEIGHT;
  localparam int unsigned DIV_W = NET_WIDTH;
  localparam int unsigned DIV_H = NET_HEIGHT;
  localparam int unsigned SH_L  = X_W + $clog2(DIV_L);
  localparam int unsigned SH_T  = X_W + $clog2(DIV_T);
  localparam int unsigned SH_W  = X_W + $clog2(DIV_W);
  localparam int unsigned SH_H  = X_W + $clog2(DIV_H);
  localparam logic [63:0] RCP_L64 = ((64'd1 << SH_L) + 64'(DIV_L) - 64'd1) / 64'(DIV_L);
  localparam logic [63:0] RCP_T64 = ((64'd1 << SH_T) + 64'(DIV_T) - 64'd1) / 64'(DIV_T);
  localparam logic [63:0] RCP_W64 = ((64'd1 << SH_W) + 64'(DIV_W) - 64'd1) / 64'(DIV_W);
  localparam logic [63:0] RCP_H64 = ((64'd1 << SH_H) + 64'(DIV_H) - 64'd1) / 64'(DIV_H);
  localparam logic [M_W-1:0] RCP_L = RCP_L64[M_W-1:0];
  localparam logic [M_W-1:0] RCP_T = RCP_T64[M_W-1:0];
  localparam logic [M_W-1:0] RCP_W = RCP_W64[M_W-1:0];
  localparam logic [M_W-1:0] RCP_H = RCP_H64[M_W-1:0];

  localparam logic [Q_W-1:0]          PIX_MAX_Q = Q_W'(16384);
  localparam logic [PIX_W-1:0]        PIX_MAX   = PIX_W'(16384);
  localparam logic signed [SUM_W-1:0] SUM_HI    = SUM_W'(16384);
  localparam logic signed [SUM_W-1:0] SUM_LO    = -SUM_W'(16384);
  localparam logic signed [SIZE_W-1:0] SIZE_HI  = SIZE_W'(16384);
  localparam logic signed [SIZE_W-1:0] SIZE_LO  = -SIZE_W'(16384);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_CLASS_COUNT  = 3'd2,
    CFG_CONF_THR     = 3'd3,
    CFG_SCORE_THR    = 3'd4
  } cfg_idx_t;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [DIM_W-1:0]        dim_t;
  typedef logic [IDX_W-1:0]        idx_t;

  typedef struct packed {
    idx_t                     class_index;
    val_t                     conf;
    logic signed [PROD_W-1:0] pl;
    logic signed [PROD_W-1:0] pt;
    logic signed [PROD_W-1:0] pw;
    logic signed [PROD_W-1:0] ph;
  } s1_t;

  typedef struct packed {
    idx_t           class_index;
    val_t           conf;
    logic [3:0]     neg;
    logic [X_W-1:0] xl;
    logic [X_W-1:0] xt;
    logic [X_W-1:0] xw;
    logic [X_W-1:0] xh;
  } s2_t;

  typedef struct packed {
    idx_t           class_index;
    val_t           conf;
    logic [3:0]     neg;
    logic [Q_W-1:0] ql;
    logic [Q_W-1:0] qt;
    logic [Q_W-1:0] qw;
    logic [Q_W-1:0] qh;
  } s3_t;

  typedef struct packed {
    idx_t               class_index;
    val_t               conf;
    logic [Q_W-1:0]     left;
    logic [Q_W-1:0]     top;
    logic signed [Q_W:0] wid;
    logic signed [Q_W:0] hgt;
  } s4_t;

  typedef struct packed {
    idx_t                     class_index;
    val_t                     box_confidence;
    logic [PIX_W-1:0]         box_left;
    logic [PIX_W-1:0]         box_top;
    logic signed [SIZE_W-1:0] box_width;
    logic signed [SIZE_W-1:0] box_height;
  } res_t;

  // magnitude of a scaled product with the fraction bits dropped
  function automatic logic [X_W-1:0] mag_frac_drop(input logic signed [PROD_W-1:0] p);
    logic [MAG_W-1:0] mag;
    mag = p[PROD_W-1] ? MAG_W'(-p) : MAG_W'(p);
    return mag[MAG_W-1:FRAC_BITS];
  endfunction

endpackage

[rtl/ydrd_in_if.sv]
// ydrd_in_if: input word channel of the detection row decoder
// depends on ydrd_pkg
interface ydrd_in_if;
  logic             valid;
  logic             ready;
  ydrd_pkg::val_t   row_value;

  modport source (output valid, output row_value, input ready);
  modport sink (input valid, input row_value, output ready);
endinterface

[rtl/ydrd_out_if.sv]
// ydrd_out_if: result word channel of the detection row decoder
// depends on ydrd_pkg
interface ydrd_out_if;
  logic                                   valid;
  logic                                   ready;
  ydrd_pkg::idx_t                         class_index;
  ydrd_pkg::val_t                         box_confidence;
  logic [ydrd_pkg::PIX_W-1:0]             box_left;
  logic [ydrd_pkg::PIX_W-1:0]             box_top;
  logic signed [ydrd_pkg::SIZE_W-1:0]     box_width;
  logic signed [ydrd_pkg::SIZE_W-1:0]     box_height;

  modport source (output valid, output class_index, output box_confidence,
                  output box_left, output box_top, output box_width,
                  output box_height, input ready);
  modport sink (input valid, input class_index, input box_confidence,
                input box_left, input box_top, input box_width,
                input box_height, output ready);
endinterface

[rtl/ydrd_box_scale.sv]
// ydrd_box_scale: four-stage box scaling pipeline with per-stage stall,
// reciprocal divide, clamp, clip and saturate; depends on ydrd_pkg, ydrd_out_if
module ydrd_box_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ydrd_pkg::s1_t        s1,
  input  logic                 s1_valid,
  output logic                 s1_ready,
  input  ydrd_pkg::dim_t       image_width,
  input  ydrd_pkg::dim_t       image_height,
  ydrd_out_if.source           out_ch
);

  logic v2_r, v3_r, v4_r, v5_r;
  logic rdy2, rdy3, rdy4, rdy5;

  ydrd_pkg::s2_t  s2_r, s2_nxt;
  ydrd_pkg::s3_t  s3_r, s3_nxt;
  ydrd_pkg::s4_t  s4_r, s4_nxt;
  ydrd_pkg::res_t res_r, res_nxt;

  logic [ydrd_pkg::RP_W-1:0] rp_l, rp_t, rp_w, rp_h;

  logic signed [ydrd_pkg::SUM_W-1:0] left_e, top_e, wid_e, hgt_e, iw_e, ih_e;
  logic signed [ydrd_pkg::SUM_W-1:0] wid_c, hgt_c;

  assign rdy5     = !v5_r || out_ch.ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign s1_ready = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= s1_valid;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
    if (rdy4) s4_r <= s4_nxt;
    if (rdy5) res_r <= res_nxt;
  end

  // magnitude and sign
  always_comb begin
    s2_nxt.class_index = s1.class_index;
    s2_nxt.conf        = s1.conf;
    s2_nxt.neg         = {s1.ph[ydrd_pkg::PROD_W-1], s1.pw[ydrd_pkg::PROD_W-1],
                          s1.pt[ydrd_pkg::PROD_W-1], s1.pl[ydrd_pkg::PROD_W-1]};
    s2_nxt.xl          = ydrd_pkg::mag_frac_drop(s1.pl);
    s2_nxt.xt          = ydrd_pkg::mag_frac_drop(s1.pt);
    s2_nxt.xw          = ydrd_pkg::mag_frac_drop(s1.pw);
    s2_nxt.xh          = ydrd_pkg::mag_frac_drop(s1.ph);
  end

  // divide by network size
  assign rp_l = {{ydrd_pkg::M_W{1'b0}}, s2_r.xl} * {{ydrd_pkg::X_W{1'b0}}, ydrd_pkg::RCP_L};
  assign rp_t = {{ydrd_pkg::M_W{1'b0}}, s2_r.xt} * {{ydrd_pkg::X_W{1'b0}}, ydrd_pkg::RCP_T};
  assign rp_w = {{ydrd_pkg::M_W{1'b0}}, s2_r.xw} * {{ydrd_pkg::X_W{1'b0}}, ydrd_pkg::RCP_W};
  assign rp_h = {{ydrd_pkg::M_W{1'b0}}, s2_r.xh} * {{ydrd_pkg::X_W{1'b0}}, ydrd_pkg::RCP_H};

  always_comb begin
    s3_nxt.class_index = s2_r.class_index;
    s3_nxt.conf        = s2_r.conf;
    s3_nxt.neg         = s2_r.neg;
    s3_nxt.ql          = ydrd_pkg::Q_W'(rp_l >> ydrd_pkg::SH_L);
    s3_nxt.qt          = ydrd_pkg::Q_W'(rp_t >> ydrd_pkg::SH_T);
    s3_nxt.qw          = ydrd_pkg::Q_W'(rp_w >> ydrd_pkg::SH_W);
    s3_nxt.qh          = ydrd_pkg::Q_W'(rp_h >> ydrd_pkg::SH_H);
  end

  // restore sign, clamp left and top at zero
  always_comb begin
    s4_nxt.class_index = s3_r.class_index;
    s4_nxt.conf        = s3_r.conf;
    s4_nxt.left        = s3_r.neg[0] ? '0 : s3_r.ql;
    s4_nxt.top         = s3_r.neg[1] ? '0 : s3_r.qt;
    s4_nxt.wid         = s3_r.neg[2] ? -$signed({1'b0, s3_r.qw}) : $signed({1'b0, s3_r.qw});
    s4_nxt.hgt         = s3_r.neg[3] ? -$signed({1'b0, s3_r.qh}) : $signed({1'b0, s3_r.qh});
  end

  // clip to image edge, saturate
  always_comb begin
    left_e = $signed({2'b00, s4_r.left});
    top_e  = $signed({2'b00, s4_r.top});
    wid_e  = $signed({s4_r.wid[ydrd_pkg::Q_W], s4_r.wid});
    hgt_e  = $signed({s4_r.hgt[ydrd_pkg::Q_W], s4_r.hgt});
    iw_e   = $signed({{(ydrd_pkg::SUM_W - ydrd_pkg::DIM_W){1'b0}}, image_width});
    ih_e   = $signed({{(ydrd_pkg::SUM_W - ydrd_pkg::DIM_W){1'b0}}, image_height});
    wid_c  = (left_e + wid_e > iw_e) ? iw_e - left_e : wid_e;
    hgt_c  = (top_e + hgt_e > ih_e) ? ih_e - top_e : hgt_e;
    if (wid_c > ydrd_pkg::SUM_HI) wid_c = ydrd_pkg::SUM_HI;
    if (wid_c < ydrd_pkg::SUM_LO) wid_c = ydrd_pkg::SUM_LO;
    if (hgt_c > ydrd_pkg::SUM_HI) hgt_c = ydrd_pkg::SUM_HI;
    if (hgt_c < ydrd_pkg::SUM_LO) hgt_c = ydrd_pkg::SUM_LO;
    res_nxt.class_index    = s4_r.class_index;
    res_nxt.box_confidence = s4_r.conf;
    res_nxt.box_left       = (s4_r.left > ydrd_pkg::PIX_MAX_Q) ? ydrd_pkg::PIX_MAX
                                                               : ydrd_pkg::PIX_W'(s4_r.left);
    res_nxt.box_top        = (s4_r.top > ydrd_pkg::PIX_MAX_Q) ? ydrd_pkg::PIX_MAX
                                                              : ydrd_pkg::PIX_W'(s4_r.top);
    res_nxt.box_width      = ydrd_pkg::SIZE_W'(wid_c);
    res_nxt.box_height     = ydrd_pkg::SIZE_W'(hgt_c);
  end

  assign out_ch.valid          = v5_r;
  assign out_ch.class_index    = res_r.class_index;
  assign out_ch.box_confidence = res_r.box_confidence;
  assign out_ch.box_left       = res_r.box_left;
  assign out_ch.box_top        = res_r.box_top;
  assign out_ch.box_width      = res_r.box_width;
  assign out_ch.box_height     = res_r.box_height;

endmodule

[rtl/yolo_detection_row_decoder.sv]
// yolo_detection_row_decoder: top level, row tracking, best class, thresholds
// and box products; depends on ydrd_pkg, ydrd_in_if, ydrd_out_if, ydrd_box_scale
//
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid/ready        | row_value
//   out_ch   | out | valid/ready        | class_index, box_confidence, box_left,
//            |     |                    | box_top, box_width, box_height
//   cfg_*    | in  | cfg_we             | cfg_index, cfg_data
//
// one word accepted per cycle while in_ch.ready is high; each word needs only one
// compare against the best score; out_ch.valid rises once a kept row's box has passed
// s1_r, s2_r, s3_r, s4_r and res_r, the five-register result pipeline with per-stage
// stall; in_ch.ready drops only when all five registers hold a box and out_ch.ready
// is low; synchronous active-low reset clears row position and pipeline valids
module yolo_detection_row_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ydrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ydrd_pkg::DIM_W-1:0]        cfg_data,
  ydrd_in_if.sink                           in_ch,
  ydrd_out_if.source                        out_ch
);

  ydrd_pkg::dim_t              iw_r, ih_r;
  logic [ydrd_pkg::CLS_W-1:0]  cls_cnt_r;
  logic [ydrd_pkg::THR_W-1:0]  conf_thr_r, score_thr_r;

  logic [ydrd_pkg::POS_W-1:0]  pos_r, pos_nxt;
  ydrd_pkg::val_t              cx_r, cy_r, w_r, h_r, obj_r, best_r, best_nxt;
  ydrd_pkg::idx_t              bcls_r, bcls_nxt;

  logic [ydrd_pkg::POS_W-1:0]  cls_use, last_pos;
  logic                        acc, row_end, take, keep;
  ydrd_pkg::val_t              v;

  logic signed [ydrd_pkg::DIFF_W-1:0] dx, dy, wx, hy;
  logic signed [ydrd_pkg::DIM_W:0]    iw_s, ih_s;

  ydrd_pkg::s1_t s1_r, s1_nxt;
  logic          s1_v_r, s1_ready, rdy1;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r        <= ydrd_pkg::IMAGE_WIDTH_RST;
      ih_r        <= ydrd_pkg::IMAGE_HEIGHT_RST;
      cls_cnt_r   <= ydrd_pkg::CLASS_COUNT_RST;
      conf_thr_r  <= ydrd_pkg::CONF_THR_RST;
      score_thr_r <= ydrd_pkg::SCORE_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ydrd_pkg::CFG_IMAGE_WIDTH:  iw_r        <= cfg_data;
        ydrd_pkg::CFG_IMAGE_HEIGHT: ih_r        <= cfg_data;
        ydrd_pkg::CFG_CLASS_COUNT:  cls_cnt_r   <= cfg_data[ydrd_pkg::CLS_W-1:0];
        ydrd_pkg::CFG_CONF_THR:     conf_thr_r  <= cfg_data[ydrd_pkg::THR_W-1:0];
        ydrd_pkg::CFG_SCORE_THR:    score_thr_r <= cfg_data[ydrd_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // row tracking
  always_comb begin
    v = in_ch.row_value;
    if (cls_cnt_r == '0) begin
      cls_use = ydrd_pkg::POS_W'(1);
    end else if (cls_cnt_r > ydrd_pkg::CLS_W'(ydrd_pkg::MAX_CLASSES)) begin
      cls_use = ydrd_pkg::POS_W'(ydrd_pkg::MAX_CLASSES);
    end else begin
      cls_use = cls_cnt_r;
    end
    last_pos = ydrd_pkg::POS_OBJ + cls_use;
    row_end  = pos_r >= last_pos;
    take     = (pos_r >= ydrd_pkg::POS_CLS0) && ((pos_r == ydrd_pkg::POS_CLS0) || (v > best_r));
    best_nxt = take ? v : best_r;
    bcls_nxt = take ? ydrd_pkg::IDX_W'(pos_r - ydrd_pkg::POS_CLS0) : bcls_r;
    keep     = row_end && ($signed(obj_r) >= $signed({1'b0, conf_thr_r}))
                       && ($signed(best_nxt) > $signed({1'b0, score_thr_r}));
    pos_nxt  = acc ? (row_end ? '0 : pos_r + ydrd_pkg::POS_W'(1)) : pos_r;
  end

  assign rdy1        = !s1_v_r || s1_ready;
  assign in_ch.ready = rdy1;
  assign acc         = in_ch.valid && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      case (pos_r)
        ydrd_pkg::POS_CX:    cx_r  <= v;
        ydrd_pkg::POS_CY:    cy_r  <= v;
        ydrd_pkg::POS_W_RAW: w_r   <= v;
        ydrd_pkg::POS_H_RAW: h_r   <= v;
        ydrd_pkg::POS_OBJ:   obj_r <= v;
        default: begin
          best_r <= best_nxt;
          bcls_r <= bcls_nxt;
        end
      endcase
    end
  end

  // box products
  always_comb begin
    iw_s = $signed({1'b0, iw_r});
    ih_s = $signed({1'b0, ih_r});
    dx   = $signed({cx_r[ydrd_pkg::VAL_W-1], cx_r, 1'b0})
           - $signed({{2{w_r[ydrd_pkg::VAL_W-1]}}, w_r});
    dy   = $signed({cy_r[ydrd_pkg::VAL_W-1], cy_r, 1'b0})
           - $signed({{2{h_r[ydrd_pkg::VAL_W-1]}}, h_r});
    wx   = $signed({{2{w_r[ydrd_pkg::VAL_W-1]}}, w_r});
    hy   = $signed({{2{h_r[ydrd_pkg::VAL_W-1]}}, h_r});
    s1_nxt.class_index = bcls_nxt;
    s1_nxt.conf        = obj_r;
    s1_nxt.pl          = ydrd_pkg::PROD_W'(dx * iw_s);
    s1_nxt.pt          = ydrd_pkg::PROD_W'(dy * ih_s);
    s1_nxt.pw          = ydrd_pkg::PROD_W'(wx * iw_s);
    s1_nxt.ph          = ydrd_pkg::PROD_W'(hy * ih_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= acc && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
  end

  ydrd_box_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1           (s1_r),
    .s1_valid     (s1_v_r),
    .s1_ready     (s1_ready),
    .image_width  (iw_r),
    .image_height (ih_r),
    .out_ch       (out_ch)
  );

`ifndef SYNTH
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= ydrd_pkg::POS_LIMIT)
    else $error("row position beyond longest row");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && row_end) |=> (pos_r == '0))
    else $error("row position not cleared after last word");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_v_r)
    else $error("input stalled with empty product stage");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.box_left <= ydrd_pkg::PIX_MAX)
                      && (out_ch.box_top <= ydrd_pkg::PIX_MAX)
                      && (out_ch.box_width <= ydrd_pkg::SIZE_HI)
                      && (out_ch.box_width >= ydrd_pkg::SIZE_LO)
                      && (out_ch.box_height <= ydrd_pkg::SIZE_HI)
                      && (out_ch.box_height >= ydrd_pkg::SIZE_LO)))
    else $error("box field outside saturation range");
`endif

endmodule

[tb/yolo_detection_row_decoder_tb.sv]
// testbench for yolo_detection_row_decoder: streams detector rows through the
// word channels, predicts every kept box and checks results in order
// depends on ydrd_pkg, ydrd_in_if, ydrd_out_if and the rtl top level
module yolo_detection_row_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam ydrd_pkg::val_t VAL_MAX = 24'h7FFFFF;
  localparam ydrd_pkg::val_t VAL_MIN = 24'h800000;

  class box_tracker;
    localparam longint DIV_X = longint'(ydrd_pkg::NET_WIDTH) * 4096;
    localparam longint DIV_Y = longint'(ydrd_pkg::NET_HEIGHT) * 4096;
    localparam longint PIX_LIM = 16384;

    ydrd_pkg::dim_t             img_w = ydrd_pkg::IMAGE_WIDTH_RST;
    ydrd_pkg::dim_t             img_h = ydrd_pkg::IMAGE_HEIGHT_RST;
    logic [ydrd_pkg::CLS_W-1:0] class_regs = ydrd_pkg::CLASS_COUNT_RST;
    logic [ydrd_pkg::THR_W-1:0] conf_thr = ydrd_pkg::CONF_THR_RST;
    logic [ydrd_pkg::THR_W-1:0] score_thr = ydrd_pkg::SCORE_THR_RST;

    logic [ydrd_pkg::POS_W-1:0] row_pos = '0;
    ydrd_pkg::val_t ctr_x = '0;
    ydrd_pkg::val_t ctr_y = '0;
    ydrd_pkg::val_t raw_w = '0;
    ydrd_pkg::val_t raw_h = '0;
    ydrd_pkg::val_t obj = '0;
    ydrd_pkg::val_t top_score = '0;
    ydrd_pkg::idx_t top_class = '0;

    ydrd_pkg::res_t boxes_due[$];
    int             mismatches = 0;

    function void set_reg(ydrd_pkg::cfg_idx_t idx, logic [ydrd_pkg::DIM_W-1:0] data);
      case (idx)
        ydrd_pkg::CFG_IMAGE_WIDTH:  img_w = data;
        ydrd_pkg::CFG_IMAGE_HEIGHT: img_h = data;
        ydrd_pkg::CFG_CLASS_COUNT:  class_regs = data[ydrd_pkg::CLS_W-1:0];
        ydrd_pkg::CFG_CONF_THR:     conf_thr = data[ydrd_pkg::THR_W-1:0];
        ydrd_pkg::CFG_SCORE_THR:    score_thr = data[ydrd_pkg::THR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned classes_used();
      if (class_regs == 0) return 1;
      if (class_regs > ydrd_pkg::MAX_CLASSES) return ydrd_pkg::MAX_CLASSES;
      return class_regs;
    endfunction

    function void take_word(ydrd_pkg::val_t v);
      int unsigned last;
      longint iw, ih, lf, tp, wd, ht, cx, cy, bw, bh;
      ydrd_pkg::res_t box;
      last = 4 + classes_used();
      case (row_pos)
        ydrd_pkg::POS_CX:    ctr_x = v;
        ydrd_pkg::POS_CY:    ctr_y = v;
        ydrd_pkg::POS_W_RAW: raw_w = v;
        ydrd_pkg::POS_H_RAW: raw_h = v;
        ydrd_pkg::POS_OBJ:   obj = v;
        default: begin
          if (row_pos == ydrd_pkg::POS_CLS0 || v > top_score) begin
            top_score = v;
            top_class = ydrd_pkg::idx_t'(row_pos - ydrd_pkg::POS_CLS0);
          end
        end
      endcase
      if (row_pos < last) begin
        row_pos = row_pos + 1'b1;
        return;
      end
      row_pos = '0;
      if (longint'(obj) < longint'(conf_thr)) return;
      if (longint'(top_score) <= longint'(score_thr)) return;
      iw = img_w;
      ih = img_h;
      cx = ctr_x;
      cy = ctr_y;
      bw = raw_w;
      bh = raw_h;
      lf = ((2 * cx - bw) * iw) / (2 * DIV_X);
      tp = ((2 * cy - bh) * ih) / (2 * DIV_Y);
      wd = (bw * iw) / DIV_X;
      ht = (bh * ih) / DIV_Y;
      if (lf < 0) lf = 0;
      if (tp < 0) tp = 0;
      if (lf + wd > iw) wd = iw - lf;
      if (tp + ht > ih) ht = ih - tp;
      if (lf > PIX_LIM) lf = PIX_LIM;
      if (tp > PIX_LIM) tp = PIX_LIM;
      if (wd > PIX_LIM) wd = PIX_LIM;
      if (wd < -PIX_LIM) wd = -PIX_LIM;
      if (ht > PIX_LIM) ht = PIX_LIM;
      if (ht < -PIX_LIM) ht = -PIX_LIM;
      box.class_index    = top_class;
      box.box_confidence = obj;
      box.box_left       = lf[ydrd_pkg::PIX_W-1:0];
      box.box_top        = tp[ydrd_pkg::PIX_W-1:0];
      box.box_width      = wd[ydrd_pkg::SIZE_W-1:0];
      box.box_height     = ht[ydrd_pkg::SIZE_W-1:0];
      boxes_due.insert(boxes_due.size(), box);
    endfunction

    function void check_box(ydrd_pkg::res_t got);
      ydrd_pkg::res_t want;
      if (boxes_due.size() == 0) begin
        $error("result word with no box expected");
        mismatches++;
        return;
      end
      want = boxes_due.pop_front();
      if (got.class_index !== want.class_index) begin
        $error("class_index: expected %0d, actual %0d", want.class_index, got.class_index);
        mismatches++;
      end
      if (got.box_confidence !== want.box_confidence) begin
        $error("box_confidence: expected %0d, actual %0d",
               want.box_confidence, got.box_confidence);
        mismatches++;
      end
      if (got.box_left !== want.box_left) begin
        $error("box_left: expected %0d, actual %0d", want.box_left, got.box_left);
        mismatches++;
      end
      if (got.box_top !== want.box_top) begin
        $error("box_top: expected %0d, actual %0d", want.box_top, got.box_top);
        mismatches++;
      end
      if (got.box_width !== want.box_width) begin
        $error("box_width: expected %0d, actual %0d", want.box_width, got.box_width);
        mismatches++;
      end
      if (got.box_height !== want.box_height) begin
        $error("box_height: expected %0d, actual %0d", want.box_height, got.box_height);
        mismatches++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [ydrd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ydrd_pkg::DIM_W-1:0]     cfg_data;

  ydrd_in_if  in_bus ();
  ydrd_out_if out_bus ();

  yolo_detection_row_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_bus.sink),
    .out_ch    (out_bus.source)
  );

  box_tracker sb = new();
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_out = 1'b0;

  ydrd_pkg::val_t directed_words [24] = '{
    VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MAX,
    24'sd1310720, 24'sd1310720, 24'sd409600, 24'sd409600, 24'sd2048, 24'sd2049,
    24'sd40960, 24'sd2600000, 24'sd204800, 24'sd900000, 24'sd2047, 24'sd8000,
    VAL_MIN, VAL_MAX, 24'sd0, 24'sd0, 24'sd4096, 24'sd2048
  };

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic ydrd_pkg::val_t pick_value();
    int unsigned pos;
    int unsigned sel;
    pos = sb.row_pos;
    sel = $urandom_range(0, 9);
    if (pos <= ydrd_pkg::POS_H_RAW) begin
      case (sel)
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return ydrd_pkg::val_t'($urandom);
        default: begin
          if (pos <= ydrd_pkg::POS_CY) begin
            return ydrd_pkg::val_t'(int'($urandom_range(0, 2800000)) - 100000);
          end
          return ydrd_pkg::val_t'($urandom_range(0, 1500000));
        end
      endcase
    end
    if (pos == ydrd_pkg::POS_OBJ) begin
      case (sel)
        0: return ydrd_pkg::val_t'($urandom);
        1: return ydrd_pkg::val_t'(int'(sb.conf_thr) - 1 + int'($urandom_range(0, 2)));
        default: return ydrd_pkg::val_t'(sb.conf_thr + $urandom_range(0, 8192));
      endcase
    end
    case (sel)
      0: return ydrd_pkg::val_t'($urandom);
      1: return ydrd_pkg::val_t'(sb.score_thr + $urandom_range(0, 1));
      2: return ydrd_pkg::val_t'(4096);
      default: return ydrd_pkg::val_t'($urandom_range(0, 12288));
    endcase
  endfunction

  task automatic send_word(input ydrd_pkg::val_t v);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.row_value <= v;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.take_word(v);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.boxes_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic program_regs(input int unsigned w, input int unsigned h,
                              input int unsigned cls, input int unsigned conf,
                              input int unsigned score);
    ydrd_pkg::cfg_idx_t idx;
    int unsigned vals [5];
    vals = '{w, h, cls, conf, score};
    for (int i = 0; i < 5; i++) begin
      idx = ydrd_pkg::cfg_idx_t'(i);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= ydrd_pkg::DIM_W'(vals[i]);
      @(posedge clk);
      sb.set_reg(idx, ydrd_pkg::DIM_W'(vals[i]));
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h,
                           input int unsigned cls, input int unsigned conf,
                           input int unsigned score, input int unsigned words,
                           input bit s_idle, input bit r_idle, input bit hold);
    drain();
    program_regs(w, h, cls, conf, score);
    send_idle = s_idle;
    recv_idle = r_idle;
    hold_out  = hold;
    for (int unsigned k = 0; k < words; k++) send_word(pick_value());
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int unsigned stall;
    ydrd_pkg::res_t got;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      stall = recv_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      got.class_index    = out_bus.class_index;
      got.box_confidence = out_bus.box_confidence;
      got.box_left       = out_bus.box_left;
      got.box_top        = out_bus.box_top;
      got.box_width      = out_bus.box_width;
      got.box_height     = out_bus.box_height;
      sb.check_box(got);
    end
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= ydrd_pkg::CFG_IMAGE_WIDTH;
    cfg_data         <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.row_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_words[i]) send_word(directed_words[i]);

    run_phase(640, 480, 1, 2048, 2048, 120, 1'b1, 1'b1, 1'b0);
    run_phase(1280, 720, 80, 1000, 1500, 200, 1'b0, 1'b0, 1'b0);
    run_phase(0, 0, 2, 0, 0, 80, 1'b1, 1'b0, 1'b0);
    run_phase(32767, 32767, 3, 4096, 4096, 100, 1'b0, 1'b1, 1'b0);
    run_phase(1, 1, 128, 8191, 0, 140, 1'b1, 1'b1, 1'b0);
    run_phase(16384, 16384, 200, 0, 8191, 150, 1'b1, 1'b1, 1'b0);
    run_phase(320, 240, 0, 100, 50, 80, 1'b1, 1'b1, 1'b0);
    run_phase(640, 640, 1, 0, 0, 180, 1'b0, 1'b1, 1'b1);
    run_phase(16384, 1, 255, 2048, 2048, 60, 1'b1, 1'b1, 1'b0);
    run_phase(2, 16383, 5, 4095, 4095, 100, 1'b1, 1'b1, 1'b0);

    in_bus.valid <= 1'b0;
    while (sb.boxes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[yolo_detection_row_decoder.f]
rtl/ydrd_pkg.sv
rtl/ydrd_in_if.sv
rtl/ydrd_out_if.sv
rtl/ydrd_box_scale.sv
rtl/yolo_detection_row_decoder.sv
tb/yolo_detection_row_decoder_tb.sv
